### sv/cgpa_pkg.sv
// shared types and widths for the complex gram power accumulator
`default_nettype none

package cgpa_pkg;

	localparam int SAMPLE_W    = 16;
	localparam int TERM_W      = 33;  // sum of two 16x16 products
	localparam int SLICE_W     = 41;
	localparam int GROUP_W     = 45;
	localparam int POWER_W     = 62;
	localparam int SCALED_W    = SLICE_W - 12;
	localparam int SQUARE_W    = 57;
	localparam int MEAN_PWR_W  = 58;
	localparam int MEAN_CPX_W  = 41;
	localparam int IN_DATA_W   = 64;
	localparam int OUT_DATA_W  = 144;

	// one snapshot after the product stage, as it waits in the queue
	typedef struct packed {
		logic signed [TERM_W-1:0] re_term;
		logic signed [TERM_W-1:0] im_term;
		logic                     end_of_slice;
		logic                     end_of_group;
	} term_entry_t;

endpackage

`default_nettype wire

### sv/cgpa_front.sv
// front end: accepts snapshots and forms the real and imaginary product terms
`default_nettype none

module cgpa_front
	import cgpa_pkg::*;
#(
	parameter int QUEUE_DEPTH = 4,
	parameter int CNT_W       = $clog2(QUEUE_DEPTH + 1)
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_axis_tvalid,
	output logic                      s_axis_tready,
	input  wire logic [IN_DATA_W-1:0] s_axis_tdata,
	input  wire logic                 s_axis_tlast,
	input  wire logic                 s_axis_tuser,
	input  wire logic [CNT_W-1:0]     q_count,
	output logic                      push,
	output term_entry_t               push_entry
);

	logic signed [SAMPLE_W-1:0] lr, li, rr, ri;
	logic                       take;
	logic [CNT_W+1:0]           in_flight;

	logic signed [2*SAMPLE_W-1:0] p_rr_s1, p_ii_s1, p_ri_s1, p_ir_s1;
	logic                         eos_s1, eog_s1, valid_s1;
	term_entry_t                  entry_s2;
	logic                         valid_s2;

	assign lr = $signed(s_axis_tdata[15:0]);
	assign li = $signed(s_axis_tdata[31:16]);
	assign rr = $signed(s_axis_tdata[47:32]);
	assign ri = $signed(s_axis_tdata[63:48]);

	// credit check: queue entries plus requests still in the two product stages
	assign in_flight = {2'b00, q_count} + {{(CNT_W+1){1'b0}}, valid_s1}
		+ {{(CNT_W+1){1'b0}}, valid_s2};
	assign s_axis_tready = in_flight < (CNT_W+2)'(QUEUE_DEPTH);
	assign take = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= take;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		p_rr_s1 <= lr * rr;
		p_ii_s1 <= li * ri;
		p_ri_s1 <= lr * ri;
		p_ir_s1 <= li * rr;
		eos_s1  <= s_axis_tlast;
		eog_s1  <= s_axis_tuser;
		entry_s2.re_term      <= {p_rr_s1[31], p_rr_s1} + {p_ii_s1[31], p_ii_s1};
		entry_s2.im_term      <= {p_ri_s1[31], p_ri_s1} - {p_ir_s1[31], p_ir_s1};
		entry_s2.end_of_slice <= eos_s1;
		entry_s2.end_of_group <= eog_s1;
	end

	assign push       = valid_s2;
	assign push_entry = entry_s2;

endmodule

`default_nettype wire

### sv/cgpa_queue.sv
// short queue of product terms between front and back
`default_nettype none

module cgpa_queue
	import cgpa_pkg::*;
#(
	parameter int QUEUE_DEPTH = 4,
	parameter int CNT_W       = $clog2(QUEUE_DEPTH + 1)
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire term_entry_t  push_entry,
	input  wire logic         pop,
	output logic              head_valid,
	output term_entry_t       head_entry,
	output logic [CNT_W-1:0]  count
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

	term_entry_t        mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               do_pop;

	assign head_valid = count_q != '0;
	assign head_entry = mem_q[rd_ptr_q];
	assign count      = count_q;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

### sv/cgpa_back.sv
// back end: slice, group and power accumulation with saturation, result register
`default_nettype none

module cgpa_back
	import cgpa_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  head_valid,
	input  wire term_entry_t           head_entry,
	output logic                       pop,
	output logic                       m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0]      m_axis_tdata
);

	logic advance;

	// slice stage
	logic signed [SLICE_W-1:0] slice_re_q, slice_im_q;
	logic        [SLICE_W:0]   sum_re, sum_im;
	logic signed [SLICE_W-1:0] sat_re, sat_im;

	// fold stage inputs
	logic signed [SLICE_W-1:0] fold_re_s1, fold_im_s1;
	logic                      fold_eog_s1, fold_valid_s1;

	// group stage
	logic signed [GROUP_W-1:0] group_re_q, group_im_q;
	logic        [GROUP_W:0]   gsum_re, gsum_im;
	logic signed [GROUP_W-1:0] gsat_re, gsat_im;
	logic signed [SCALED_W-1:0] scaled_re, scaled_im;
	logic signed [2*SCALED_W-1:0] sq_re_full, sq_im_full;

	logic [SQUARE_W-1:0]       sq_re_s2, sq_im_s2;
	logic signed [GROUP_W-1:0] res_re_s2, res_im_s2;
	logic                      eog_s2, valid_s2;

	// power stage
	logic [POWER_W-1:0] power_q;
	logic [MEAN_PWR_W-1:0] slice_pwr;
	logic [POWER_W:0]   psum;
	logic [POWER_W-1:0] psat;

	logic                   out_valid_q;
	logic [MEAN_PWR_W-1:0]  out_power_q;
	logic [MEAN_CPX_W-1:0]  out_re_q, out_im_q;

	assign advance = !out_valid_q || m_axis_tready;
	assign pop     = advance && head_valid;

	always_comb begin
		sum_re = {slice_re_q[SLICE_W-1], slice_re_q}
			+ {{(SLICE_W+1-TERM_W){head_entry.re_term[TERM_W-1]}}, head_entry.re_term};
		sum_im = {slice_im_q[SLICE_W-1], slice_im_q}
			+ {{(SLICE_W+1-TERM_W){head_entry.im_term[TERM_W-1]}}, head_entry.im_term};
		if (sum_re[SLICE_W] != sum_re[SLICE_W-1]) begin
			sat_re = sum_re[SLICE_W] ? {1'b1, {(SLICE_W-1){1'b0}}} : {1'b0, {(SLICE_W-1){1'b1}}};
		end else begin
			sat_re = sum_re[SLICE_W-1:0];
		end
		if (sum_im[SLICE_W] != sum_im[SLICE_W-1]) begin
			sat_im = sum_im[SLICE_W] ? {1'b1, {(SLICE_W-1){1'b0}}} : {1'b0, {(SLICE_W-1){1'b1}}};
		end else begin
			sat_im = sum_im[SLICE_W-1:0];
		end
	end

	always_comb begin
		gsum_re = {group_re_q[GROUP_W-1], group_re_q}
			+ {{(GROUP_W+1-SLICE_W){fold_re_s1[SLICE_W-1]}}, fold_re_s1};
		gsum_im = {group_im_q[GROUP_W-1], group_im_q}
			+ {{(GROUP_W+1-SLICE_W){fold_im_s1[SLICE_W-1]}}, fold_im_s1};
		if (gsum_re[GROUP_W] != gsum_re[GROUP_W-1]) begin
			gsat_re = gsum_re[GROUP_W] ? {1'b1, {(GROUP_W-1){1'b0}}} : {1'b0, {(GROUP_W-1){1'b1}}};
		end else begin
			gsat_re = gsum_re[GROUP_W-1:0];
		end
		if (gsum_im[GROUP_W] != gsum_im[GROUP_W-1]) begin
			gsat_im = gsum_im[GROUP_W] ? {1'b1, {(GROUP_W-1){1'b0}}} : {1'b0, {(GROUP_W-1){1'b1}}};
		end else begin
			gsat_im = gsum_im[GROUP_W-1:0];
		end
		scaled_re  = $signed(fold_re_s1[SLICE_W-1:12]);
		scaled_im  = $signed(fold_im_s1[SLICE_W-1:12]);
		sq_re_full = scaled_re * scaled_re;
		sq_im_full = scaled_im * scaled_im;
	end

	always_comb begin
		slice_pwr = {1'b0, sq_re_s2} + {1'b0, sq_im_s2};
		psum = {1'b0, power_q} + {{(POWER_W+1-MEAN_PWR_W){1'b0}}, slice_pwr};
		psat = psum[POWER_W] ? {POWER_W{1'b1}} : psum[POWER_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slice_re_q    <= '0;
			slice_im_q    <= '0;
			group_re_q    <= '0;
			group_im_q    <= '0;
			power_q       <= '0;
			fold_valid_s1 <= 1'b0;
			valid_s2      <= 1'b0;
			out_valid_q   <= 1'b0;
		end else if (advance) begin
			fold_valid_s1 <= pop && head_entry.end_of_slice;
			if (pop) begin
				if (head_entry.end_of_slice) begin
					slice_re_q <= '0;
					slice_im_q <= '0;
				end else begin
					slice_re_q <= sat_re;
					slice_im_q <= sat_im;
				end
			end
			valid_s2 <= fold_valid_s1;
			if (fold_valid_s1) begin
				if (fold_eog_s1) begin
					group_re_q <= '0;
					group_im_q <= '0;
				end else begin
					group_re_q <= gsat_re;
					group_im_q <= gsat_im;
				end
			end
			out_valid_q <= valid_s2 && eog_s2;
			if (valid_s2) begin
				power_q <= eog_s2 ? '0 : psat;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			fold_re_s1  <= sat_re;
			fold_im_s1  <= sat_im;
			fold_eog_s1 <= head_entry.end_of_group;
			sq_re_s2    <= sq_re_full[SQUARE_W-1:0];
			sq_im_s2    <= sq_im_full[SQUARE_W-1:0];
			res_re_s2   <= gsat_re;
			res_im_s2   <= gsat_im;
			eog_s2      <= fold_eog_s1;
			out_power_q <= psat[POWER_W-1:4];
			out_re_q    <= res_re_s2[GROUP_W-1:4];
			out_im_q    <= res_im_s2[GROUP_W-1:4];
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(OUT_DATA_W-MEAN_PWR_W-2*MEAN_CPX_W){1'b0}},
		out_im_q, out_re_q, out_power_q};

endmodule

`default_nettype wire

### sv/complex_gram_power_accumulator_core.sv
// a group-ending snapshot passes the product registers, the queue, the fold, square and output registers
// throughput: one snapshot per cycle unless the back stalls; four 16x16 multipliers
//   in front, two 29x29 squarers and saturating adders in the back, all pipelined
// the back stalls only while a result waits in the output register; a queue of
//   QUEUE_DEPTH entries with credit-based ready absorbs that stall
// reset: asynchronous, active low; clears every accumulator, valid flag and queue pointer
`default_nettype none

module complex_gram_power_accumulator_core
	import cgpa_pkg::*;
#(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// snapshot requests
	input  wire logic                  s_axis_tvalid,
	output logic                       s_axis_tready,
	// left_re [15:0], left_im [31:16], right_re [47:32], right_im [63:48]
	input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
	// end_of_slice
	input  wire logic                  s_axis_tlast,
	// end_of_group (only honored together with end_of_slice)
	input  wire logic                  s_axis_tuser,
	// group results
	output logic                       m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	// mean_power [57:0], mean_re [98:58], mean_im [139:99], zero pad [143:140]
	output logic [OUT_DATA_W-1:0]      m_axis_tdata
);

	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	// front to queue
	logic        push;
	term_entry_t push_entry;

	// queue to back
	logic             pop;
	logic             head_valid;
	term_entry_t      head_entry;
	logic [CNT_W-1:0] q_count;

	// front: input capture, four cross products, real and imaginary terms
	cgpa_front #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.CNT_W       (CNT_W)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.s_axis_tuser  (s_axis_tuser),
		.q_count       (q_count),
		.push          (push),
		.push_entry    (push_entry)
	);

	// decoupling queue; its fill count feeds the front's credit check
	cgpa_queue #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.CNT_W       (CNT_W)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head_valid (head_valid),
		.head_entry (head_entry),
		.count      (q_count)
	);

	// back: slice sums, fold into group sums and power, emit at group end
	cgpa_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head_valid    (head_valid),
		.head_entry    (head_entry),
		.pop           (pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

endmodule

`default_nettype wire
